// ===== design/utf8d_pkg.sv =====
// shared types, constants and helper functions for the utf-8 stream decoder
// no dependencies; compiled first
package utf8d_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;

    // input item codes
    localparam logic FUNC_FEED  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // continuation byte test: top two bits are 10
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    // sequence length codes
    localparam logic [2:0] LEN_BAD   = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic            is_invalid;
        logic [CP_W-1:0] code_point;
        logic            last;
    } result_t;

    // results produced by one item, handed to the result buffer
    typedef struct packed {
        logic [1:0] num;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        priority if (b < 8'h80)
            len = LEN_ONE;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = LEN_TWO;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = LEN_THREE;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = LEN_FOUR;
        else
            len = LEN_BAD;
        return len;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic result_t mk_invalid();
        result_t r;
        r.is_invalid = 1'b1;
        r.code_point = '0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_point(input logic [CP_W-1:0] cp);
        result_t r;
        r.is_invalid = 1'b0;
        r.code_point = cp;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/utf8d_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on utf8d_pkg for field widths
interface utf8d_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [utf8d_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface utf8d_out_if;
    logic                       valid;
    logic                       ready;
    logic                       is_invalid;
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                       last;

    modport source (output valid, output is_invalid, output code_point, output last,
                    input ready);
    modport sink (input valid, input is_invalid, input code_point, input last,
                  output ready);
endinterface

// ===== design/utf8d_seq.sv =====
// pending sequence state and per-item decode logic
// depends on utf8d_pkg
module utf8d_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         func,
    input  logic [utf8d_pkg::BYTE_W-1:0] data_byte,
    input  logic                         advance,
    output utf8d_pkg::push_t             push
);
    import utf8d_pkg::*;

    logic [1:0]        cnt_reg, cnt_next;
    logic [BYTE_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [BYTE_W-1:0] p0_next, p1_next, p2_next;

    logic [2:0]      need;
    logic [2:0]      have;
    logic [2:0]      blen;
    logic [CP_W-1:0] v2, v3, v4;
    logic            ok2, ok3, ok4, dec_ok;
    logic [CP_W-1:0] dec_cp;
    push_t           p;

    // candidate decodes for each sequence length
    always_comb
    begin
        v2  = {10'd0, p0_reg[4:0], data_byte[5:0]};
        v3  = {5'd0, p0_reg[3:0], p1_reg[5:0], data_byte[5:0]};
        v4  = {p0_reg[2:0], p1_reg[5:0], p2_reg[5:0], data_byte[5:0]};
        ok2 = is_cont(data_byte) && (v2 >= 21'h80);
        ok3 = is_cont(p1_reg) && is_cont(data_byte) && (v3 >= 21'h800)
              && !(v3 >= 21'hD800 && v3 <= 21'hDFFF);
        ok4 = is_cont(p1_reg) && is_cont(p2_reg) && is_cont(data_byte)
              && (v4 >= 21'h10000) && (v4 <= 21'h10FFFF);
        need = seq_len(p0_reg);
        have = {1'b0, cnt_reg} + 3'd1;
        blen = seq_len(data_byte);
        unique case (need)
            LEN_TWO:
            begin
                dec_ok = ok2;
                dec_cp = v2;
            end
            LEN_THREE:
            begin
                dec_ok = ok3;
                dec_cp = v3;
            end
            LEN_FOUR:
            begin
                dec_ok = ok4;
                dec_cp = v4;
            end
            default:
            begin
                dec_ok = 1'b0;
                dec_cp = '0;
            end
        endcase
    end

    // results and next pending state for the current item
    always_comb
    begin
        p        = '0;
        cnt_next = cnt_reg;
        p0_next  = p0_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        if (func == FUNC_FLUSH)
        begin
            if (cnt_reg != 2'd0)
            begin
                cnt_next = 2'd0;
                p.num    = 2'd1;
                p.res0   = mk_invalid();
            end
        end
        else if (cnt_reg == 2'd0)
        begin
            if (blen == LEN_ONE)
            begin
                p.num  = 2'd1;
                p.res0 = mk_point({13'd0, data_byte});
            end
            else if (blen == LEN_BAD)
            begin
                p.num  = 2'd1;
                p.res0 = mk_invalid();
            end
            else
            begin
                p0_next  = data_byte;
                cnt_next = 2'd1;
            end
        end
        else if (need < LEN_TWO)
        begin
            // corrupted lead in state: drop it
            cnt_next = 2'd0;
            p.num    = 2'd1;
            p.res0   = mk_invalid();
        end
        else if (have < need)
        begin
            if (!is_cont(data_byte))
            begin
                // broken sequence, then resync on this byte
                cnt_next = 2'd0;
                p.res0   = mk_invalid();
                if (blen == LEN_ONE)
                begin
                    p.num  = 2'd2;
                    p.res1 = mk_point({13'd0, data_byte});
                end
                else if (blen != LEN_BAD)
                begin
                    p.num    = 2'd1;
                    p0_next  = data_byte;
                    cnt_next = 2'd1;
                end
                else
                begin
                    p.num  = 2'd2;
                    p.res1 = mk_invalid();
                end
            end
            else
            begin
                if (cnt_reg == 2'd1)
                    p1_next = data_byte;
                else
                    p2_next = data_byte;
                cnt_next = have[1:0];
            end
        end
        else
        begin
            // final byte of the sequence
            cnt_next = 2'd0;
            p.num    = 2'd1;
            if (have == need && dec_ok)
                p.res0 = mk_point(dec_cp);
            else
                p.res0 = mk_invalid();
        end
        // mark the final result of the item
        if (p.num == 2'd1)
            p.res0.last = 1'b1;
        if (p.num == 2'd2)
            p.res1.last = 1'b1;
    end

    assign push = p;

    // pending state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            p0_reg  <= '0;
            p1_reg  <= '0;
            p2_reg  <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_next;
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
        end
    end

endmodule

// ===== design/utf8d_out_buf.sv =====
// two-entry result buffer; takes up to two results per cycle, sends one per cycle while dout is ready
// depends on utf8d_pkg and utf8d_if
module utf8d_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  utf8d_pkg::push_t push,
    output logic [1:0]       room,
    utf8d_out_if.source      dout
);
    import utf8d_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;
    logic [1:0] cnt_a;
    result_t    base0;

    assign pop  = (count_reg != 2'd0) && dout.ready;
    assign room = 2'd2 - count_reg + {1'b0, pop};

    // drive the head entry
    assign dout.valid      = (count_reg != 2'd0);
    assign dout.is_invalid = slot0_reg.is_invalid;
    assign dout.code_point = slot0_reg.code_point;
    assign dout.last       = slot0_reg.last;

    // shift out the sent entry, then append new results
    always_comb
    begin
        cnt_a      = count_reg - {1'b0, pop};
        base0      = pop ? slot1_reg : slot0_reg;
        slot0_next = base0;
        slot1_next = slot1_reg;
        if (cnt_a == 2'd0 && push.num != 2'd0)
            slot0_next = push.res0;
        if (cnt_a == 2'd1 && push.num != 2'd0)
            slot1_next = push.res0;
        else if (cnt_a == 2'd0 && push.num == 2'd2)
            slot1_next = push.res1;
        count_next = cnt_a + push.num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// top level of the utf-8 stream decoder: input register, decode, result buffer
// depends on utf8d_pkg, utf8d_if, utf8d_seq and utf8d_out_buf
//
//  port   dir   contents
//  din    sink  func, data_byte
//  dout   src   is_invalid, code_point, last
//
// an item waits in the input register until the result buffer has room for its
// results, which then enter the two-entry result buffer; its head drives dout
// one item per cycle while items give one result and dout is ready; an item
// with two results sends them one at a time through the single result port
// reset clears the pending sequence and both registers
// a stall at dout holds items in the buffer and input register
module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    din,
    utf8d_out_if.source dout
);
    import utf8d_pkg::*;

    logic              in_vld_reg;
    logic              func_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              advance;
    logic [1:0]        room;
    push_t             push;
    push_t             push_gated;

    // the held item moves on when the buffer has space for its results
    assign advance  = in_vld_reg && (room >= push.num);
    assign din.ready = !in_vld_reg || advance;

    assign push_gated = advance ? push : '0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (din.ready)
            in_vld_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            func_reg <= din.func;
            byte_reg <= din.data_byte;
        end
    end

    utf8d_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func_reg),
        .data_byte (byte_reg),
        .advance   (advance),
        .push      (push)
    );

    utf8d_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_gated),
        .room  (room),
        .dout  (dout)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for utf8_stream_decoder: directed table, then random byte streams
// depends on utf8d_pkg, utf8d_if and the utf8_stream_decoder design files
module tb;
    import utf8d_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned CALM_ITEMS   = 150;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DIRECTED_N   = 26;

    typedef struct {
        logic        func;
        logic [7:0]  data;
        bit          typed;
        int          n;
        result_t     r0;
        result_t     r1;
    } row_t;

    logic clk;
    logic rst_n;

    utf8d_in_if  din_ch ();
    utf8d_out_if dout_ch ();

    utf8_stream_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    // decoder state as the testbench tracks it
    logic [1:0] pend_cnt;
    logic [7:0] pend_bytes [3];

    result_t decoded_q [$];
    int      mismatches;
    int      items_sent;
    bit      calm;
    row_t    plan [DIRECTED_N];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("utf8_stream_decoder regression: fail");
        $finish;
    end

    function automatic result_t cp_res(input logic [CP_W-1:0] cp, input bit lst);
        result_t r;
        r.is_invalid = 1'b0;
        r.code_point = cp;
        r.last       = lst;
        return r;
    endfunction

    function automatic result_t inv_res(input bit lst);
        result_t r;
        r.is_invalid = 1'b1;
        r.code_point = '0;
        r.last       = lst;
        return r;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (b < 8'h80)
            return LEN_ONE;
        if (b >= 8'hC2 && b <= 8'hDF)
            return LEN_TWO;
        if (b >= 8'hE0 && b <= 8'hEF)
            return LEN_THREE;
        if (b >= 8'hF0 && b <= 8'hF4)
            return LEN_FOUR;
        return LEN_BAD;
    endfunction

    function automatic bit cont_byte(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // strict rfc 3629 decode of a complete sequence
    function automatic bit strict_decode(input logic [7:0] s [4], input logic [2:0] n,
                                         output logic [CP_W-1:0] cp);
        logic [31:0] v;
        cp = '0;
        case (n)
            LEN_TWO:   v = 32'(s[0] & 8'h1F);
            LEN_THREE: v = 32'(s[0] & 8'h0F);
            LEN_FOUR:  v = 32'(s[0] & 8'h07);
            default:   return 1'b0;
        endcase
        for (int i = 1; i < n; i++)
        begin
            if (!cont_byte(s[i]))
                return 1'b0;
            v = (v << 6) | 32'(s[i] & 8'h3F);
        end
        if (n == LEN_TWO && v < 32'h80)
            return 1'b0;
        if (n == LEN_THREE && (v < 32'h800 || (v >= 32'hD800 && v <= 32'hDFFF)))
            return 1'b0;
        if (n == LEN_FOUR && (v < 32'h10000 || v > 32'h10FFFF))
            return 1'b0;
        cp = v[CP_W-1:0];
        return 1'b1;
    endfunction

    // advance the tracked state by one transaction and list the results it causes
    task automatic decode_step(input logic f, input logic [7:0] b,
                               output int n, output result_t r [2]);
        logic [2:0]      need;
        int              have;
        logic [7:0]      s [4];
        logic [CP_W-1:0] cp;
        n    = 0;
        r[0] = '0;
        r[1] = '0;
        s    = '{default: 8'h00};
        if (f == FUNC_FLUSH)
        begin
            if (pend_cnt != 2'd0)
            begin
                pend_cnt = 2'd0;
                r[n] = inv_res(1'b0);
                n++;
            end
        end
        else if (pend_cnt == 2'd0)
        begin
            need = lead_len(b);
            if (need == LEN_ONE)
            begin
                r[n] = cp_res(CP_W'(b), 1'b0);
                n++;
            end
            else if (need == LEN_BAD)
            begin
                r[n] = inv_res(1'b0);
                n++;
            end
            else
            begin
                pend_bytes[0] = b;
                pend_cnt      = 2'd1;
            end
        end
        else
        begin
            need = lead_len(pend_bytes[0]);
            have = int'(pend_cnt) + 1;
            if (need < LEN_TWO)
            begin
                // pending lead can never be bad; handled as a bad lead anyway
                pend_cnt = 2'd0;
                r[n] = inv_res(1'b0);
                n++;
            end
            else if (have < int'(need))
            begin
                if (!cont_byte(b))
                begin
                    // break in the sequence: mark it, then resync on this byte
                    pend_cnt = 2'd0;
                    r[n] = inv_res(1'b0);
                    n++;
                    if (b < 8'h80)
                    begin
                        r[n] = cp_res(CP_W'(b), 1'b0);
                        n++;
                    end
                    else if (lead_len(b) > LEN_ONE)
                    begin
                        pend_bytes[0] = b;
                        pend_cnt      = 2'd1;
                    end
                    else
                    begin
                        r[n] = inv_res(1'b0);
                        n++;
                    end
                end
                else
                begin
                    pend_bytes[pend_cnt] = b;
                    pend_cnt             = 2'(have);
                end
            end
            else
            begin
                // final byte: decode the whole sequence
                for (int i = 0; i < int'(pend_cnt); i++)
                    s[i] = pend_bytes[i];
                s[pend_cnt] = b;
                pend_cnt    = 2'd0;
                if (have == int'(need) && strict_decode(s, need, cp))
                    r[n] = cp_res(cp, 1'b0);
                else
                    r[n] = inv_res(1'b0);
                n++;
            end
        end
        if (n > 0)
            r[n-1].last = 1'b1;
    endtask

    // drive one transaction, wait for acceptance, then predict it
    task automatic feed_item(input logic f, input logic [7:0] b,
                             output int n, output result_t r [2]);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            din_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.func      <= f;
        din_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!din_ch.ready);
        decode_step(f, b, n, r);
    endtask

    task automatic send(input logic f, input logic [7:0] b);
        int      n;
        result_t r [2];
        feed_item(f, b, n, r);
        for (int i = 0; i < n; i++)
            decoded_q.push_back(r[i]);
        items_sent++;
        calm = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
    endtask

    // raw utf-8 encoding of v in n bytes, no validity checks
    function automatic void utf8_encode(input logic [CP_W-1:0] v, input int n,
                                        output logic [7:0] s [4]);
        s = '{default: 8'h00};
        case (n)
            1: s[0] = v[7:0];
            2:
            begin
                s[0] = {3'b110, v[10:6]};
                s[1] = {2'b10, v[5:0]};
            end
            3:
            begin
                s[0] = {4'b1110, v[15:12]};
                s[1] = {2'b10, v[11:6]};
                s[2] = {2'b10, v[5:0]};
            end
            default:
            begin
                s[0] = {5'b11110, v[20:18]};
                s[1] = {2'b10, v[17:12]};
                s[2] = {2'b10, v[11:6]};
                s[3] = {2'b10, v[5:0]};
            end
        endcase
    endfunction

    // legal scalar value for an n-byte form, biased to the range ends
    function automatic logic [CP_W-1:0] pick_scalar(input int n);
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        logic [CP_W-1:0] v;
        case (n)
            1:
            begin
                lo = 21'h0;
                hi = 21'h7F;
            end
            2:
            begin
                lo = 21'h80;
                hi = 21'h7FF;
            end
            3:
            begin
                lo = 21'h800;
                hi = 21'hFFFF;
            end
            default:
            begin
                lo = 21'h10000;
                hi = 21'h10FFFF;
            end
        endcase
        case ($urandom_range(0, 7))
            0:       v = lo;
            1:       v = hi;
            default: v = CP_W'($urandom_range(int'(hi), int'(lo)));
        endcase
        // move surrogates into the legal block below them
        if (v >= 21'hD800 && v <= 21'hDFFF)
            v = v ^ 21'h1000;
        return v;
    endfunction

    // one random chunk of the stream
    task automatic send_group();
        int              kind;
        int              n;
        int              k;
        logic [CP_W-1:0] v;
        logic [7:0]      s [4];
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            // well-formed scalar
            n = $urandom_range(1, 4);
            utf8_encode(pick_scalar(n), n, s);
            for (int i = 0; i < n; i++)
                send(FUNC_FEED, s[i]);
        end
        else if (kind < 60)
        begin
            // complete but illegal: overlong, surrogate or above range
            case ($urandom_range(0, 2))
                0:
                begin
                    n = $urandom_range(2, 4);
                    v = (n == 2) ? CP_W'($urandom_range(0, 'h7F)) :
                        (n == 3) ? CP_W'($urandom_range(0, 'h7FF)) :
                                   CP_W'($urandom_range(0, 'hFFFF));
                end
                1:
                begin
                    n = 3;
                    v = CP_W'($urandom_range('hD800, 'hDFFF));
                end
                default:
                begin
                    n = 4;
                    v = CP_W'($urandom_range('h110000, 'h1FFFFF));
                end
            endcase
            utf8_encode(v, n, s);
            for (int i = 0; i < n; i++)
                send(FUNC_FEED, s[i]);
        end
        else if (kind < 75)
        begin
            // truncated sequence followed by one more transaction: ascii, lead, bad or continuation byte, or flush
            n = $urandom_range(2, 4);
            k = $urandom_range(1, n - 1);
            utf8_encode(pick_scalar(n), n, s);
            for (int i = 0; i < k; i++)
                send(FUNC_FEED, s[i]);
            case ($urandom_range(0, 3))
                0: send(FUNC_FEED, 8'($urandom_range(0, 'h7F)));
                1: send(FUNC_FEED, 8'($urandom_range('hC2, 'hF4)));
                2: send(FUNC_FEED, $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                                        : 8'($urandom_range('hF5, 'hFF)));
                default: send(FUNC_FLUSH, 8'($urandom));
            endcase
        end
        else if (kind < 85)
            send(FUNC_FLUSH, 8'($urandom));
        else
            send(FUNC_FEED, 8'($urandom));
    endtask

    // result checker and output stall pattern
    initial
    begin
        int      burst;
        bit      rdy;
        result_t want;
        burst = 0;
        rdy   = 1'b0;
        dout_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (dout_ch.valid && dout_ch.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: inv=%b cp=%h last=%b",
                                 $realtime, dout_ch.is_invalid, dout_ch.code_point,
                                 dout_ch.last);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (dout_ch.is_invalid !== want.is_invalid ||
                        dout_ch.code_point !== want.code_point ||
                        dout_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: exp inv=%b cp=%h last=%b, got inv=%b cp=%h last=%b",
                                     $realtime, want.is_invalid, want.code_point, want.last,
                                     dout_ch.is_invalid, dout_ch.code_point, dout_ch.last);
                    end
                end
            end
            if (burst == 0)
            begin
                if (calm)
                begin
                    rdy   = 1'b1;
                    burst = 1;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    rdy   = 1'b0;
                    burst = $urandom_range(1, 10);
                end
                else
                begin
                    rdy   = 1'b1;
                    burst = $urandom_range(1, 30);
                end
            end
            burst--;
            dout_ch.ready <= rdy && rst_n;
        end
    end

    // reset, directed table, random stream, end of run
    initial
    begin
        int      n;
        result_t r [2];
        mismatches = 0;
        items_sent = 0;
        calm       = 1'b0;
        pend_cnt   = 2'd0;
        pend_bytes = '{default: 8'h00};
        rst_n            <= 1'b0;
        din_ch.valid     <= 1'b0;
        din_ch.func      <= FUNC_FEED;
        din_ch.data_byte <= 8'h00;

        plan = '{
            // ascii extremes, bad leads, flush with nothing pending
            '{FUNC_FEED,  8'h00, 1'b1, 1, cp_res(21'h0, 1'b1),      result_t'('0)},
            '{FUNC_FEED,  8'h7F, 1'b1, 1, cp_res(21'h7F, 1'b1),     result_t'('0)},
            '{FUNC_FEED,  8'h80, 1'b1, 1, inv_res(1'b1),            result_t'('0)},
            '{FUNC_FEED,  8'hFF, 1'b1, 1, inv_res(1'b1),            result_t'('0)},
            '{FUNC_FEED,  8'hC0, 1'b1, 1, inv_res(1'b1),            result_t'('0)},
            '{FUNC_FLUSH, 8'h00, 1'b1, 0, result_t'('0),            result_t'('0)},
            // two-byte range ends
            '{FUNC_FEED,  8'hC2, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'h80, 1'b1, 1, cp_res(21'h80, 1'b1),     result_t'('0)},
            '{FUNC_FEED,  8'hDF, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hBF, 1'b1, 1, cp_res(21'h7FF, 1'b1),    result_t'('0)},
            // smallest three-byte value
            '{FUNC_FEED,  8'hE0, 1'b0, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hA0, 1'b0, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'h80, 1'b0, 0, result_t'('0),            result_t'('0)},
            // largest scalar
            '{FUNC_FEED,  8'hF4, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'h8F, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hBF, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hBF, 1'b1, 1, cp_res(21'h10FFFF, 1'b1), result_t'('0)},
            // break before the final byte, resync on ascii
            '{FUNC_FEED,  8'hE1, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'h41, 1'b1, 2, inv_res(1'b0),            cp_res(21'h41, 1'b1)},
            // break with a new lead, then a non-continuation final byte
            '{FUNC_FEED,  8'hE1, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hC3, 1'b1, 1, inv_res(1'b1),            result_t'('0)},
            '{FUNC_FEED,  8'h41, 1'b1, 1, inv_res(1'b1),            result_t'('0)},
            // break on a bad lead gives two marks
            '{FUNC_FEED,  8'hE1, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FEED,  8'hFF, 1'b1, 2, inv_res(1'b0),            inv_res(1'b1)},
            // flush while pending
            '{FUNC_FEED,  8'hF0, 1'b1, 0, result_t'('0),            result_t'('0)},
            '{FUNC_FLUSH, 8'hFF, 1'b1, 1, inv_res(1'b1),            result_t'('0)}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (plan[i])
        begin
            feed_item(plan[i].func, plan[i].data, n, r);
            if (plan[i].typed)
            begin
                if (plan[i].n > 0)
                    decoded_q.push_back(plan[i].r0);
                if (plan[i].n > 1)
                    decoded_q.push_back(plan[i].r1);
            end
            else
            begin
                for (int j = 0; j < n; j++)
                    decoded_q.push_back(r[j]);
            end
        end

        // random stream
        while (items_sent < RANDOM_ITEMS)
            send_group();
        din_ch.valid <= 1'b0;

        // drain, then allow for the pipeline
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && decoded_q.size() == 0)
            $display("utf8_stream_decoder regression: pass");
        else
            $display("utf8_stream_decoder regression: fail");
        $finish;
    end

endmodule
